// ===== rtl/core/trt_pkg.sv =====
// Shared types, widths and codes of the timed rule table.
package trt_pkg;

  // Table size and result limits
  localparam int unsigned TABLE_SLOTS = 32;
  localparam int unsigned SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  // Field widths
  localparam int unsigned MODE_W = 2;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned SEC_W  = 32;
  localparam int unsigned TOD_W  = 17;
  localparam int unsigned DLY_W  = 24;
  localparam int unsigned WK_W   = 7;
  localparam int unsigned WDAY_W = 3;
  localparam int unsigned EV_W   = 3;
  localparam int unsigned WHEN_W = SEC_W + 1;

  // Rule kinds
  localparam logic KIND_DELAY  = 1'b0;
  localparam logic KIND_TIMING = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_UPSERT = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  typedef enum logic [EV_W-1:0] {
    EV_TICK_DONE = 3'd0,
    EV_FIRE      = 3'd1,
    EV_EXPIRED   = 3'd2,
    EV_STORED    = 3'd3,
    EV_FULL      = 3'd4,
    EV_REMOVED   = 3'd5
  } event_e;

  // One stored rule; when is the deadline of a delay rule or the start of a timing rule
  typedef struct packed {
    logic [ID_W-1:0]   rule_id;
    logic              kind;
    logic [WHEN_W-1:0] when;
    logic [TOD_W-1:0]  tod;
    logic              rep;
    logic [WK_W-1:0]   weekdays;
  } slot_rec_t;

  // Latched input item
  typedef struct packed {
    mode_e             mode;
    logic [ID_W-1:0]   rule_id;
    logic              kind;
    logic [SEC_W-1:0]  start;
    logic [TOD_W-1:0]  start_tod;
    logic [DLY_W-1:0]  delay;
    logic              rep;
    logic [WK_W-1:0]   weekdays;
    logic [SEC_W-1:0]  now;
    logic [WDAY_W-1:0] wday;
    logic [TOD_W-1:0]  now_tod;
  } item_t;

  typedef struct packed {
    event_e          kind;
    logic [ID_W-1:0] rule_id;
  } ev_t;

  // Requests from the scan control to the event queue
  typedef struct packed {
    logic push;
    logic fin;
    ev_t  ev;
  } evq_req_t;

  // Status from the event queue
  typedef struct packed {
    logic room;
    logic fin_ok;
  } evq_stat_t;

  // Outcome of one slot on a tick
  typedef struct packed {
    logic fire;
    logic over;
  } verdict_t;

endpackage

// ===== rtl/core/trt_in_if.sv =====
// Input channel of the timed rule table: valid, ready and one item.
interface trt_in_if;
  logic                        valid;
  logic                        ready;
  logic [trt_pkg::MODE_W-1:0]  mode;
  logic [trt_pkg::ID_W-1:0]    rule_id;
  logic                        rule_kind;
  logic [trt_pkg::SEC_W-1:0]   start_seconds;
  logic [trt_pkg::TOD_W-1:0]   start_time_of_day;
  logic [trt_pkg::DLY_W-1:0]   delay_seconds;
  logic                        repeat_req;
  logic [trt_pkg::WK_W-1:0]    weekday_mask;
  logic [trt_pkg::SEC_W-1:0]   now_seconds;
  logic [trt_pkg::WDAY_W-1:0]  now_weekday;
  logic [trt_pkg::TOD_W-1:0]   now_time_of_day;

  modport source (
    output valid, mode, rule_id, rule_kind, start_seconds, start_time_of_day,
           delay_seconds, repeat_req, weekday_mask, now_seconds, now_weekday,
           now_time_of_day,
    input  ready
  );

  modport sink (
    input  valid, mode, rule_id, rule_kind, start_seconds, start_time_of_day,
           delay_seconds, repeat_req, weekday_mask, now_seconds, now_weekday,
           now_time_of_day,
    output ready
  );
endinterface

// ===== rtl/core/trt_out_if.sv =====
// Output channel of the timed rule table: valid, ready and one result.
interface trt_out_if;
  logic                      valid;
  logic                      ready;
  logic [trt_pkg::EV_W-1:0]  event_kind;
  logic [trt_pkg::ID_W-1:0]  event_rule_id;
  logic                      last;

  modport source (
    output valid, event_kind, event_rule_id, last,
    input  ready
  );

  modport sink (
    input  valid, event_kind, event_rule_id, last,
    output ready
  );
endinterface

// ===== rtl/core/trt_rule_eval.sv =====
// Tick evaluation of one stored rule against the current time.
module trt_rule_eval (
  input  trt_pkg::slot_rec_t           rec_i,
  input  logic [trt_pkg::SEC_W-1:0]    now_i,
  input  logic [trt_pkg::WDAY_W-1:0]   wday_i,
  input  logic [trt_pkg::TOD_W-1:0]    tod_i,
  output trt_pkg::verdict_t            verdict_o
);

  logic [trt_pkg::WHEN_W:0] diff;
  logic                     reached;
  logic                     eq;
  logic                     le1;
  logic [7:0]               wk_ext;
  logic                     day_ok;

  // now minus when, one bit wider to catch a negative difference
  assign diff    = (trt_pkg::WHEN_W + 1)'(now_i) - (trt_pkg::WHEN_W + 1)'(rec_i.when);
  assign reached = ~diff[trt_pkg::WHEN_W];
  assign eq      = (diff == '0);
  assign le1     = reached & (diff[trt_pkg::WHEN_W-1:1] == '0);

  // Weekday seven reads the padding bit and never matches
  assign wk_ext = {1'b0, rec_i.weekdays};
  assign day_ok = wk_ext[wday_i];

  // Decide fire and expiry
  always_comb begin
    verdict_o = '0;
    if (rec_i.kind == trt_pkg::KIND_DELAY) begin
      verdict_o.over = reached;
      verdict_o.fire = le1;
    end else if (eq) begin
      verdict_o.fire = 1'b1;
      verdict_o.over = ~rec_i.rep;
    end else if (reached && !rec_i.rep) begin
      verdict_o.over = 1'b1;
    end else if (rec_i.rep) begin
      verdict_o.fire = day_ok && (rec_i.tod == tod_i);
    end
  end

endmodule

// ===== rtl/core/trt_event_out.sv =====
// Result queue: holds one pending event so the final one can be marked last.
module trt_event_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trt_pkg::evq_req_t   req_i,
  output trt_pkg::evq_stat_t  stat_o,
  trt_out_if.source           out_o
);

  trt_pkg::ev_t out_q, out_d;
  logic         out_last_q, out_last_d;
  logic         out_valid_q, out_valid_d;
  trt_pkg::ev_t pend_q, pend_d;
  logic         pend_valid_q, pend_valid_d;
  logic         load_ok;

  assign load_ok       = ~out_valid_q | out_o.ready;
  assign stat_o.room   = ~pend_valid_q | load_ok;
  assign stat_o.fin_ok = load_ok;

  // Move pending beat to the output, or take the final beat
  always_comb begin
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q & ~out_o.ready;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    if (req_i.push) begin
      if (pend_valid_q) begin
        out_d       = pend_q;
        out_last_d  = 1'b0;
        out_valid_d = 1'b1;
      end
      pend_d       = req_i.ev;
      pend_valid_d = 1'b1;
    end else if (req_i.fin && load_ok) begin
      out_d        = pend_valid_q ? pend_q : req_i.ev;
      out_last_d   = 1'b1;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    out_last_q <= out_last_d;
    pend_q     <= pend_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.event_kind    = out_q.kind;
  assign out_o.event_rule_id = out_q.rule_id;
  assign out_o.last          = out_last_q;

  // A push never overruns the pending beat
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.push |-> stat_o.room)
    else $error("event pushed without room");

  // Push and finish never coincide
  a_push_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.push && req_i.fin))
    else $error("push and finish together");

  // A taken finish leaves no pending event and the last beat in the output register
  a_fin_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.fin && load_ok) |=> (!pend_valid_q && out_valid_q && out_last_q))
    else $error("finish left a pending event");

  // Tick done only ever travels as the last beat
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == trt_pkg::EV_TICK_DONE) |-> out_last_q)
    else $error("tick done not marked last");

endmodule

// ===== rtl/core/timed_rule_table_core.sv =====
// Timed rule table: slot memory, scan sequencer and result queue.
//
// Input channel in_i carries one item per beat: tick, add, upsert or remove.
// Output channel out_o returns one or more result beats per item; the final
// beat of an item has last set. Both use valid/ready, a beat moves when both
// are high.
// Every item is handled by one pass over all TABLE_SLOTS slots of the rule
// memory, one slot per cycle while the pass does not stall, since the slots
// sit in a memory with one write port and one registered read port. On a
// tick, a slot that both fires and expires is visited twice, first for its
// fire and then for its expiry. The next item is accepted once the last
// result has entered the output register.
// Add and upsert write the chosen slot in the closing cycle of the pass.
// Reset empties the table at once (valid bits in flops); the rule memory
// itself is not cleared. When the receiver stalls, the pass halts on the
// slot whose event cannot be queued and resumes when ready returns.
module timed_rule_table_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  trt_in_if.sink     in_i,
  trt_out_if.source  out_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e                               state_q, state_d;
  logic [trt_pkg::SLOT_W-1:0]           ptr_q, ptr_d;
  logic                                 sub_q, sub_d;
  logic [trt_pkg::CNT_W-1:0]            cnt_q, cnt_d;
  logic                                 free_found_q, free_found_d;
  logic [trt_pkg::SLOT_W-1:0]           free_idx_q, free_idx_d;
  logic                                 match_found_q, match_found_d;
  logic [trt_pkg::SLOT_W-1:0]           match_idx_q, match_idx_d;
  logic [trt_pkg::TABLE_SLOTS-1:0]      valid_q, valid_d;
  trt_pkg::item_t                       item_q;
  trt_pkg::slot_rec_t                   slot_mem_q [trt_pkg::TABLE_SLOTS];
  trt_pkg::slot_rec_t                   rd_rec_q;
  trt_pkg::slot_rec_t                   wr_rec;
  logic [trt_pkg::SLOT_W-1:0]           rd_addr;
  logic [trt_pkg::SLOT_W-1:0]           wr_addr;
  logic                                 wr_en;
  trt_pkg::verdict_t                    verdict;
  trt_pkg::evq_req_t                    req;
  trt_pkg::evq_stat_t                   stat;

  logic in_acc;
  logic cur_valid;
  logic id_hit;
  logic last_slot;
  logic is_tick;
  logic store_op;
  logic slot_fire;
  logic slot_over;
  logic split;
  logic ev_now;
  logic capped;
  logic can_go;
  logic advance;
  logic has_target;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;

  // Latch the accepted item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.mode      <= trt_pkg::mode_e'(in_i.mode);
      item_q.rule_id   <= in_i.rule_id;
      item_q.kind      <= in_i.rule_kind;
      item_q.start     <= in_i.start_seconds;
      item_q.start_tod <= in_i.start_time_of_day;
      item_q.delay     <= in_i.delay_seconds;
      item_q.rep       <= in_i.repeat_req;
      item_q.weekdays  <= in_i.weekday_mask;
      item_q.now       <= in_i.now_seconds;
      item_q.wday      <= in_i.now_weekday;
      item_q.now_tod   <= in_i.now_time_of_day;
    end
  end

  // Rule memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[wr_addr] <= wr_rec;
    end
    rd_rec_q <= slot_mem_q[rd_addr];
  end

  // Evaluate the slot currently on the read port
  trt_rule_eval u_eval (
    .rec_i     (rd_rec_q),
    .now_i     (item_q.now),
    .wday_i    (item_q.wday),
    .tod_i     (item_q.now_tod),
    .verdict_o (verdict)
  );

  assign cur_valid  = valid_q[ptr_q];
  assign id_hit     = cur_valid && (rd_rec_q.rule_id == item_q.rule_id);
  assign last_slot  = (ptr_q == trt_pkg::SLOT_W'(trt_pkg::TABLE_SLOTS - 1));
  assign is_tick    = (item_q.mode == trt_pkg::MODE_TICK);
  assign store_op   = (item_q.mode == trt_pkg::MODE_ADD) ||
                      (item_q.mode == trt_pkg::MODE_UPSERT);
  assign slot_fire  = cur_valid & verdict.fire & ~sub_q;
  assign slot_over  = cur_valid & verdict.over;
  assign split      = slot_fire & slot_over;
  assign ev_now     = is_tick & (slot_fire | slot_over);
  assign capped     = (cnt_q == trt_pkg::CNT_W'(trt_pkg::MAX_RESULTS));
  assign can_go     = ~ev_now | capped | stat.room;
  assign advance    = (state_q == ST_SCAN) && (!is_tick || (can_go && !split));
  assign has_target = match_found_q | free_found_q;
  assign wr_addr    = match_found_q ? match_idx_q : free_idx_q;

  // Build the record to store; a delay rule keeps its deadline
  always_comb begin
    wr_rec.rule_id  = item_q.rule_id;
    wr_rec.kind     = item_q.kind;
    wr_rec.when     = (item_q.kind == trt_pkg::KIND_DELAY) ?
                      trt_pkg::WHEN_W'(item_q.start) + trt_pkg::WHEN_W'(item_q.delay) :
                      trt_pkg::WHEN_W'(item_q.start);
    wr_rec.tod      = item_q.start_tod;
    wr_rec.rep      = item_q.rep;
    wr_rec.weekdays = item_q.weekdays;
  end

  // Scan sequencer
  always_comb begin
    state_d       = state_q;
    ptr_d         = ptr_q;
    sub_d         = sub_q;
    cnt_d         = cnt_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    valid_d       = valid_q;
    rd_addr       = ptr_q;
    wr_en         = 1'b0;
    req           = '0;
    case (state_q)
      ST_IDLE: begin
        rd_addr = '0;
        if (in_acc) begin
          state_d       = ST_SCAN;
          ptr_d         = '0;
          sub_d         = 1'b0;
          cnt_d         = '0;
          free_found_d  = 1'b0;
          match_found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (is_tick) begin
          // Queue a fire or expiry beat; drop it once the cap is hit
          if (ev_now && !capped && stat.room) begin
            req.push       = 1'b1;
            req.ev.kind    = slot_fire ? trt_pkg::EV_FIRE : trt_pkg::EV_EXPIRED;
            req.ev.rule_id = rd_rec_q.rule_id;
            cnt_d          = cnt_q + 1'b1;
          end
          if (can_go) begin
            if (split) begin
              sub_d = 1'b1;
            end else begin
              sub_d = 1'b0;
              if (slot_over) begin
                valid_d[ptr_q] = 1'b0;
              end
            end
          end
        end else begin
          // Note first free slot and first id match; drop removed slots
          if (!cur_valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = ptr_q;
          end
          if ((item_q.mode == trt_pkg::MODE_UPSERT) && id_hit && !match_found_q) begin
            match_found_d = 1'b1;
            match_idx_d   = ptr_q;
          end
          if ((item_q.mode == trt_pkg::MODE_REMOVE) && id_hit) begin
            valid_d[ptr_q] = 1'b0;
          end
        end
        if (advance) begin
          if (last_slot) begin
            state_d = ST_FINISH;
          end else begin
            ptr_d   = ptr_q + 1'b1;
            rd_addr = ptr_q + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        req.fin        = 1'b1;
        req.ev.rule_id = item_q.rule_id;
        case (item_q.mode)
          trt_pkg::MODE_TICK: begin
            req.ev.kind    = trt_pkg::EV_TICK_DONE;
            req.ev.rule_id = '0;
          end
          trt_pkg::MODE_ADD, trt_pkg::MODE_UPSERT: begin
            req.ev.kind = has_target ? trt_pkg::EV_STORED : trt_pkg::EV_FULL;
          end
          default: begin
            req.ev.kind = trt_pkg::EV_REMOVED;
          end
        endcase
        if (stat.fin_ok) begin
          state_d = ST_IDLE;
          if (store_op && has_target) begin
            wr_en            = 1'b1;
            valid_d[wr_addr] = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ptr_q         <= '0;
      sub_q         <= 1'b0;
      cnt_q         <= '0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      match_found_q <= 1'b0;
      match_idx_q   <= '0;
      valid_q       <= '0;
    end else begin
      state_q       <= state_d;
      ptr_q         <= ptr_d;
      sub_q         <= sub_d;
      cnt_q         <= cnt_d;
      free_found_q  <= free_found_d;
      free_idx_q    <= free_idx_d;
      match_found_q <= match_found_d;
      match_idx_q   <= match_idx_d;
      valid_q       <= valid_d;
    end
  end

  // Result queue and output register
  trt_event_out u_event_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .stat_o (stat),
    .out_o  (out_o)
  );

  // The memory is written only when a pass closes on add or upsert
  a_wr_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_FINISH && store_op))
    else $error("rule memory written outside a store");

  // The table grows only through a memory write
  a_grow_by_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(valid_q) > $past($countones(valid_q))) |-> $past(wr_en))
    else $error("slot became valid without a store");

  // A tick pass never adds rules
  a_tick_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && is_tick) |=> ($countones(valid_q) <= $past($countones(valid_q))))
    else $error("tick added a rule");

  // The split step of a slot exists only inside a tick pass
  a_sub_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (state_q == ST_SCAN && is_tick))
    else $error("split step outside a tick pass");

endmodule
